// ===== design/bsad_pkg.sv =====
package bsad_pkg;

    localparam int RMS_W   = 24;
    localparam int KURT_W  = 16;
    localparam int WIN_W   = 7;
    localparam int CODE_W  = 2;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 56;
    localparam int OUT_PAD = OUT_W - (2 * CODE_W + RMS_W + KURT_W + WIN_W);

    localparam logic CMD_RESTART = 1'b1;

    localparam logic [CODE_W-1:0] ST_CAL    = 2'd0;
    localparam logic [CODE_W-1:0] ST_NORMAL = 2'd1;
    localparam logic [CODE_W-1:0] ST_ALERT  = 2'd2;

    localparam logic [CODE_W-1:0] CAUSE_NONE = 2'd0;
    localparam logic [CODE_W-1:0] CAUSE_RMS  = 2'd1;
    localparam logic [CODE_W-1:0] CAUSE_KURT = 2'd2;

    localparam int RMS_FLOOR_DEN  = 10;
    localparam int KURT_FLOOR_OFS = 384;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SQ   = 9'b000000010,
        S_MEAN = 9'b000000100,
        S_EX2  = 9'b000001000,
        S_MSQ  = 9'b000010000,
        S_ROOT = 9'b000100000,
        S_FLR  = 9'b001000000,
        S_LIM  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

endpackage

// ===== design/bsad_mul.sv =====
module bsad_mul #(
    parameter int W = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic           o_busy,
    output logic [2*W-1:0] o_p
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [2*W-1:0]   r_a;
    logic [W-1:0]     r_b;
    logic [2*W-1:0]   r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= (2*W)'(i_a);
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= {r_a[2*W-2:0], 1'b0};
            r_b <= {1'b0, r_b[W-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_p    = r_p;

endmodule

// ===== design/bsad_div.sv =====
module bsad_div #(
    parameter int NW = 58,
    parameter int DW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_n,
    input  logic [DW-1:0] i_d,
    output logic          o_busy,
    output logic [NW-1:0] o_q
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_d;
    logic [NW-1:0]    r_q;
    logic [DW:0]      w_trial;
    logic [DW:0]      w_diff;
    logic             w_ge;
    logic [DW-1:0]    n_rem;

    always_comb begin
        w_trial = {r_rem, r_q[NW-1]};
        w_diff  = w_trial - {1'b0, r_d};
        w_ge    = (w_trial >= {1'b0, r_d});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_d   <= i_d;
            r_q   <= i_n;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[NW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_q    = r_q;

endmodule

// ===== design/bsad_sqrt.sv =====
module bsad_sqrt #(
    parameter int VW = 48
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [VW-1:0]   i_v,
    output logic            o_busy,
    output logic [VW/2-1:0] o_root
);

    localparam int RW    = VW / 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_v;
    logic [RW:0]      r_rem;
    logic [RW-1:0]    r_root;
    logic [RW+2:0]    w_cur;
    logic [RW+2:0]    w_trial;
    logic [RW+2:0]    w_diff;
    logic             w_ge;

    always_comb begin
        w_cur   = {r_rem, r_v[VW-1:VW-2]};
        w_trial = {1'b0, r_root, 2'b01};
        w_diff  = w_cur - w_trial;
        w_ge    = (w_cur >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(RW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_v;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v    <= {r_v[VW-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[RW:0] : w_cur[RW:0];
            r_root <= {r_root[RW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ===== design/baseline_sigma_anomaly_detector.sv =====
// Restart and monitoring transactions pass through S_DONE and load the output register once it is free.
// A learning transaction squares its rms and kurtosis values in the bit-serial squarers (S_SQ).
// The last baseline window then runs S_MEAN, S_EX2, S_MSQ, S_ROOT and S_FLR on the bit-serial
// multiplier, divider and square-root units; one transaction at a time.
// Synchronous active-low reset clears learning, both thresholds and the output valid flag.
module baseline_sigma_anomaly_detector #(
    parameter int BASELINE_WINDOWS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // rms_value [23:0], kurtosis_value [39:24]
    input  logic [bsad_pkg::IN_W-1:0]  s_axis_tdata,
    // command [0]
    input  logic [0:0]                 s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status [1:0], alert_cause [3:2], rms_threshold [27:4],
    // kurtosis_threshold [43:28], windows_learned [50:44], zero fill [55:51]
    output logic [bsad_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int RW     = bsad_pkg::RMS_W;
    localparam int KW     = bsad_pkg::KURT_W;
    localparam int CW     = $clog2(BASELINE_WINDOWS + 1);
    localparam int RSUM_W = RW + CW;
    localparam int RSQ_W  = 2 * RW + CW;
    localparam int KSUM_W = KW + CW;
    localparam int KSQ_W  = 2 * KW + CW;
    localparam int DV_W   = (CW > 4) ? CW : 4;

    bsad_pkg::t_state r_state;
    logic             r_go;
    logic [CW-1:0]    r_count;
    logic [RSUM_W-1:0] r_rms_sum;
    logic [RSQ_W-1:0]  r_rms_sq;
    logic [KSUM_W-1:0] r_kurt_sum;
    logic [KSQ_W-1:0]  r_kurt_sq;
    logic [RW-1:0]     r_rms_limit;
    logic [KW-1:0]     r_kurt_limit;

    logic [RW-1:0]     r_in_rms;
    logic [KW-1:0]     r_in_kurt;
    logic [RW-1:0]     r_mean_r;
    logic [KW-1:0]     r_mean_k;
    logic [2*RW-1:0]   r_var_r;
    logic [2*KW-1:0]   r_var_k;
    logic [RW-1:0]     r_sig_r;
    logic [KW-1:0]     r_sig_k;
    logic [RW:0]       r_flr_r;
    logic [bsad_pkg::CODE_W-1:0] r_status;
    logic [bsad_pkg::CODE_W-1:0] r_cause;

    logic                      r_out_valid;
    logic [bsad_pkg::OUT_W-1:0] r_out_data;

    logic            w_in_acc;
    logic            w_out_load;
    logic            w_compute;
    logic            w_start;
    logic            w_units_idle;
    logic            w_step_done;
    logic            w_full;
    logic            w_cmd;
    logic [RW-1:0]   w_rms_in;
    logic [KW-1:0]   w_kurt_in;

    logic            w_mul_r_busy;
    logic            w_mul_k_busy;
    logic            w_div_r_busy;
    logic            w_div_k_busy;
    logic            w_sqrt_r_busy;
    logic            w_sqrt_k_busy;
    logic [2*RW-1:0] w_mul_r_p;
    logic [2*KW-1:0] w_mul_k_p;
    logic [RSQ_W-1:0] w_div_r_q;
    logic [KSQ_W-1:0] w_div_k_q;
    logic [RW-1:0]   w_sqrt_r;
    logic [KW-1:0]   w_sqrt_k;

    logic [RW-1:0]   w_mul_r_a;
    logic [KW-1:0]   w_mul_k_a;
    logic [RSQ_W-1:0] w_div_r_n;
    logic [KSQ_W-1:0] w_div_k_n;
    logic [DV_W-1:0] w_div_d;
    logic [RW+3:0]   w_mean13;

    logic [RW+1:0]   w_rms_thr;
    logic [RW+1:0]   w_rms_flr;
    logic [RW+1:0]   w_rms_pick;
    logic [KW+1:0]   w_kurt_cand;
    logic [KW+1:0]   w_kurt_flr;
    logic [KW+1:0]   w_kurt_pick;
    logic [RW-1:0]   n_rms_limit;
    logic [KW-1:0]   n_kurt_limit;
    logic [2*RW-1:0] n_var_r;
    logic [2*KW-1:0] n_var_k;

    assign w_cmd     = s_axis_tuser[0];
    assign w_rms_in  = s_axis_tdata[RW-1:0];
    assign w_kurt_in = s_axis_tdata[RW+KW-1:RW];

    assign s_axis_tready = (r_state == bsad_pkg::S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == bsad_pkg::S_DONE) && (!r_out_valid || m_axis_tready);
    assign w_full        = (r_count == CW'(BASELINE_WINDOWS));

    assign w_compute = (r_state == bsad_pkg::S_SQ)  || (r_state == bsad_pkg::S_MEAN) ||
                       (r_state == bsad_pkg::S_EX2) || (r_state == bsad_pkg::S_MSQ)  ||
                       (r_state == bsad_pkg::S_ROOT) || (r_state == bsad_pkg::S_FLR);
    assign w_start   = w_compute && !r_go;
    assign w_units_idle = !(w_mul_r_busy || w_mul_k_busy || w_div_r_busy ||
                            w_div_k_busy || w_sqrt_r_busy || w_sqrt_k_busy);
    assign w_step_done  = r_go && w_units_idle;

    always_comb begin
        w_mul_r_a = (r_state == bsad_pkg::S_SQ) ? r_in_rms  : r_mean_r;
        w_mul_k_a = (r_state == bsad_pkg::S_SQ) ? r_in_kurt : r_mean_k;
        w_mean13  = ({4'b0, r_mean_r} << 3) + ({4'b0, r_mean_r} << 2) + {4'b0, r_mean_r};
        w_div_d   = (r_state == bsad_pkg::S_FLR) ? DV_W'(bsad_pkg::RMS_FLOOR_DEN)
                                                 : DV_W'(BASELINE_WINDOWS);
        w_div_r_n = RSQ_W'(r_rms_sum);
        w_div_k_n = KSQ_W'(r_kurt_sum);
        if (r_state == bsad_pkg::S_EX2) begin
            w_div_r_n = r_rms_sq;
            w_div_k_n = r_kurt_sq;
        end else if (r_state == bsad_pkg::S_FLR) begin
            w_div_r_n = RSQ_W'(w_mean13);
        end
    end

    bsad_mul #(.W(RW)) u_mul_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start && ((r_state == bsad_pkg::S_SQ) || (r_state == bsad_pkg::S_MSQ))),
        .i_a     (w_mul_r_a),
        .i_b     (w_mul_r_a),
        .o_busy  (w_mul_r_busy),
        .o_p     (w_mul_r_p)
    );

    bsad_mul #(.W(KW)) u_mul_k (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start && ((r_state == bsad_pkg::S_SQ) || (r_state == bsad_pkg::S_MSQ))),
        .i_a     (w_mul_k_a),
        .i_b     (w_mul_k_a),
        .o_busy  (w_mul_k_busy),
        .o_p     (w_mul_k_p)
    );

    bsad_div #(.NW(RSQ_W), .DW(DV_W)) u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start && ((r_state == bsad_pkg::S_MEAN) || (r_state == bsad_pkg::S_EX2) ||
                              (r_state == bsad_pkg::S_FLR))),
        .i_n     (w_div_r_n),
        .i_d     (w_div_d),
        .o_busy  (w_div_r_busy),
        .o_q     (w_div_r_q)
    );

    bsad_div #(.NW(KSQ_W), .DW(DV_W)) u_div_k (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start && ((r_state == bsad_pkg::S_MEAN) || (r_state == bsad_pkg::S_EX2))),
        .i_n     (w_div_k_n),
        .i_d     (w_div_d),
        .o_busy  (w_div_k_busy),
        .o_q     (w_div_k_q)
    );

    bsad_sqrt #(.VW(2 * RW)) u_sqrt_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start && (r_state == bsad_pkg::S_ROOT)),
        .i_v     (r_var_r),
        .o_busy  (w_sqrt_r_busy),
        .o_root  (w_sqrt_r)
    );

    bsad_sqrt #(.VW(2 * KW)) u_sqrt_k (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start && (r_state == bsad_pkg::S_ROOT)),
        .i_v     (r_var_k),
        .o_busy  (w_sqrt_k_busy),
        .o_root  (w_sqrt_k)
    );

    // A negative variance is clamped to zero.
    always_comb begin
        n_var_r = (r_var_r > w_mul_r_p) ? (r_var_r - w_mul_r_p) : '0;
        n_var_k = (r_var_k > w_mul_k_p) ? (r_var_k - w_mul_k_p) : '0;
    end

    always_comb begin
        w_rms_thr  = {2'b0, r_mean_r} + {2'b0, r_sig_r} + {1'b0, r_sig_r, 1'b0};
        w_rms_flr  = (RW+2)'(r_flr_r);
        w_rms_pick = (w_rms_thr < w_rms_flr) ? w_rms_flr : w_rms_thr;
        n_rms_limit = (w_rms_pick[RW+1:RW] != 2'b00) ? '1 : w_rms_pick[RW-1:0];

        w_kurt_cand = {2'b0, r_mean_k} + {2'b0, r_sig_k} + {1'b0, r_sig_k, 1'b0};
        w_kurt_flr  = {2'b0, r_mean_k} + (KW+2)'(bsad_pkg::KURT_FLOOR_OFS);
        w_kurt_pick = (w_kurt_cand < w_kurt_flr) ? w_kurt_flr : w_kurt_cand;
        n_kurt_limit = (w_kurt_pick[KW+1:KW] != 2'b00) ? '1 : w_kurt_pick[KW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bsad_pkg::S_IDLE;
            r_go         <= 1'b0;
            r_count      <= '0;
            r_rms_sum    <= '0;
            r_rms_sq     <= '0;
            r_kurt_sum   <= '0;
            r_kurt_sq    <= '0;
            r_rms_limit  <= '0;
            r_kurt_limit <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_go <= w_compute && !w_step_done;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                bsad_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_cmd == bsad_pkg::CMD_RESTART) begin
                            r_count      <= '0;
                            r_rms_sum    <= '0;
                            r_rms_sq     <= '0;
                            r_kurt_sum   <= '0;
                            r_kurt_sq    <= '0;
                            r_rms_limit  <= '0;
                            r_kurt_limit <= '0;
                            r_state      <= bsad_pkg::S_DONE;
                        end else if (!w_full) begin
                            r_state <= bsad_pkg::S_SQ;
                        end else begin
                            r_state <= bsad_pkg::S_DONE;
                        end
                    end
                end
                bsad_pkg::S_SQ: begin
                    if (w_step_done) begin
                        r_count    <= r_count + CW'(1);
                        r_rms_sum  <= r_rms_sum + RSUM_W'(r_in_rms);
                        r_rms_sq   <= r_rms_sq + RSQ_W'(w_mul_r_p);
                        r_kurt_sum <= r_kurt_sum + KSUM_W'(r_in_kurt);
                        r_kurt_sq  <= r_kurt_sq + KSQ_W'(w_mul_k_p);
                        r_state    <= (r_count == CW'(BASELINE_WINDOWS - 1)) ?
                                      bsad_pkg::S_MEAN : bsad_pkg::S_DONE;
                    end
                end
                bsad_pkg::S_MEAN: begin
                    if (w_step_done) begin
                        r_state <= bsad_pkg::S_EX2;
                    end
                end
                bsad_pkg::S_EX2: begin
                    if (w_step_done) begin
                        r_state <= bsad_pkg::S_MSQ;
                    end
                end
                bsad_pkg::S_MSQ: begin
                    if (w_step_done) begin
                        r_state <= bsad_pkg::S_ROOT;
                    end
                end
                bsad_pkg::S_ROOT: begin
                    if (w_step_done) begin
                        r_state <= bsad_pkg::S_FLR;
                    end
                end
                bsad_pkg::S_FLR: begin
                    if (w_step_done) begin
                        r_state <= bsad_pkg::S_LIM;
                    end
                end
                bsad_pkg::S_LIM: begin
                    r_rms_limit  <= n_rms_limit;
                    r_kurt_limit <= n_kurt_limit;
                    r_state      <= bsad_pkg::S_DONE;
                end
                bsad_pkg::S_DONE: begin
                    if (w_out_load) begin
                        r_state <= bsad_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= bsad_pkg::S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            bsad_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_in_rms  <= w_rms_in;
                    r_in_kurt <= w_kurt_in;
                    if ((w_cmd == bsad_pkg::CMD_RESTART) || !w_full) begin
                        r_status <= bsad_pkg::ST_CAL;
                        r_cause  <= bsad_pkg::CAUSE_NONE;
                    end else if (w_rms_in > r_rms_limit) begin
                        r_status <= bsad_pkg::ST_ALERT;
                        r_cause  <= bsad_pkg::CAUSE_RMS;
                    end else if (w_kurt_in > r_kurt_limit) begin
                        r_status <= bsad_pkg::ST_ALERT;
                        r_cause  <= bsad_pkg::CAUSE_KURT;
                    end else begin
                        r_status <= bsad_pkg::ST_NORMAL;
                        r_cause  <= bsad_pkg::CAUSE_NONE;
                    end
                end
            end
            bsad_pkg::S_MEAN: begin
                if (w_step_done) begin
                    r_mean_r <= w_div_r_q[RW-1:0];
                    r_mean_k <= w_div_k_q[KW-1:0];
                end
            end
            bsad_pkg::S_EX2: begin
                if (w_step_done) begin
                    r_var_r <= w_div_r_q[2*RW-1:0];
                    r_var_k <= w_div_k_q[2*KW-1:0];
                end
            end
            bsad_pkg::S_MSQ: begin
                if (w_step_done) begin
                    r_var_r <= n_var_r;
                    r_var_k <= n_var_k;
                end
            end
            bsad_pkg::S_ROOT: begin
                if (w_step_done) begin
                    r_sig_r <= w_sqrt_r;
                    r_sig_k <= w_sqrt_k;
                end
            end
            bsad_pkg::S_FLR: begin
                if (w_step_done) begin
                    r_flr_r <= w_div_r_q[RW:0];
                end
            end
            bsad_pkg::S_DONE: begin
                if (w_out_load) begin
                    r_out_data <= {{bsad_pkg::OUT_PAD{1'b0}},
                                   bsad_pkg::WIN_W'(r_count),
                                   r_kurt_limit,
                                   r_rms_limit,
                                   r_cause,
                                   r_status};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_alert_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_data[1:0] == bsad_pkg::ST_ALERT) ==
                         (r_out_data[3:2] != bsad_pkg::CAUSE_NONE)))
        else $error("alert status and alert cause disagree");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BASELINE_WINDOWS))
        else $error("learned window count beyond the baseline length");

    a_limits_zero_while_learning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_full |-> ((r_rms_limit == '0) && (r_kurt_limit == '0)))
        else $error("threshold set before the baseline is complete");

    a_square_only_while_learning: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsad_pkg::S_SQ) |-> !w_full)
        else $error("accumulation entered with a full baseline");
`endif

endmodule

// ===== dv/sigma_verdict_checker.sv =====
module sigma_verdict_checker #(
    parameter int WINDOWS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    // rms_value [23:0], kurtosis_value [39:24]
    input  logic [bsad_pkg::IN_W-1:0]  i_in_data,
    // command [0]
    input  logic [0:0]                 i_in_user,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    // status [1:0], alert_cause [3:2], rms_threshold [27:4],
    // kurtosis_threshold [43:28], windows_learned [50:44], zero fill [55:51]
    input  logic [bsad_pkg::OUT_W-1:0] i_out_data,
    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_verdicts_seen
);

    localparam logic [63:0] RMS_TOP  = (64'd1 << bsad_pkg::RMS_W) - 64'd1;
    localparam logic [63:0] KURT_TOP = (64'd1 << bsad_pkg::KURT_W) - 64'd1;

    typedef struct packed {
        logic [bsad_pkg::OUT_PAD-1:0] fill;
        logic [bsad_pkg::WIN_W-1:0]   windows;
        logic [bsad_pkg::KURT_W-1:0]  kurt_level;
        logic [bsad_pkg::RMS_W-1:0]   rms_thr;
        logic [bsad_pkg::CODE_W-1:0]  cause;
        logic [bsad_pkg::CODE_W-1:0]  status;
    } t_verdict;

    logic [63:0] learned     = '0;
    logic [63:0] rms_acc     = '0;
    logic [63:0] rms_sq_acc  = '0;
    logic [63:0] kurt_acc    = '0;
    logic [63:0] kurt_sq_acc = '0;
    logic [63:0] rms_limit   = '0;
    logic [63:0] kurt_limit  = '0;

    t_verdict expected_verdicts[$];
    int       mismatches = 0;

    // Standard deviation in raw units, rounded down, with the mean returned alongside.
    function automatic logic [63:0] spread_of(input logic [63:0] sum, input logic [63:0] sq,
                                              output logic [63:0] mean);
        logic [63:0] ex2;
        logic [63:0] msq;
        logic [63:0] root;
        mean = sum / 64'(WINDOWS);
        ex2  = sq / 64'(WINDOWS);
        msq  = mean * mean;
        root = '0;
        if (ex2 > msq) begin
            for (int b = 31; b >= 0; b--) begin
                root[b] = 1'b1;
                if (root * root > ex2 - msq)
                    root[b] = 1'b0;
            end
        end
        return root;
    endfunction

    function automatic t_verdict judge_window(input logic cmd,
                                              input logic [bsad_pkg::RMS_W-1:0] rms,
                                              input logic [bsad_pkg::KURT_W-1:0] kurt);
        t_verdict    v;
        logic [63:0] mean;
        logic [63:0] sigma;
        logic [63:0] thr;
        logic [63:0] flr;
        v        = '0;
        v.status = bsad_pkg::ST_CAL;
        v.cause  = bsad_pkg::CAUSE_NONE;
        if (cmd == bsad_pkg::CMD_RESTART) begin
            learned     = '0;
            rms_acc     = '0;
            rms_sq_acc  = '0;
            kurt_acc    = '0;
            kurt_sq_acc = '0;
            rms_limit   = '0;
            kurt_limit  = '0;
        end else if (learned < 64'(WINDOWS)) begin
            learned     = learned + 64'd1;
            rms_acc     = rms_acc + 64'(rms);
            rms_sq_acc  = rms_sq_acc + 64'(rms) * 64'(rms);
            kurt_acc    = kurt_acc + 64'(kurt);
            kurt_sq_acc = kurt_sq_acc + 64'(kurt) * 64'(kurt);
            if (learned == 64'(WINDOWS)) begin
                sigma = spread_of(rms_acc, rms_sq_acc, mean);
                thr   = mean + 64'd3 * sigma;
                flr   = (mean * 64'd13) / 64'(bsad_pkg::RMS_FLOOR_DEN);
                if (thr < flr)
                    thr = flr;
                rms_limit = (thr > RMS_TOP) ? RMS_TOP : thr;
                sigma = spread_of(kurt_acc, kurt_sq_acc, mean);
                thr   = mean + 64'd3 * sigma;
                flr   = mean + 64'(bsad_pkg::KURT_FLOOR_OFS);
                if (thr < flr)
                    thr = flr;
                kurt_limit = (thr > KURT_TOP) ? KURT_TOP : thr;
            end
        end else if (64'(rms) > rms_limit) begin
            v.status = bsad_pkg::ST_ALERT;
            v.cause  = bsad_pkg::CAUSE_RMS;
        end else if (64'(kurt) > kurt_limit) begin
            v.status = bsad_pkg::ST_ALERT;
            v.cause  = bsad_pkg::CAUSE_KURT;
        end else begin
            v.status = bsad_pkg::ST_NORMAL;
        end
        v.rms_thr    = rms_limit[bsad_pkg::RMS_W-1:0];
        v.kurt_level = kurt_limit[bsad_pkg::KURT_W-1:0];
        v.windows    = learned[bsad_pkg::WIN_W-1:0];
        return v;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict seen;
        t_verdict want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                seen = t_verdict'(i_out_data);
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected transaction: expected none, actual %h",
                             $time, i_out_data);
                    mismatches++;
                end else begin
                    want = expected_verdicts.pop_front();
                    check_field("status", 64'(want.status), 64'(seen.status));
                    check_field("alert_cause", 64'(want.cause), 64'(seen.cause));
                    check_field("rms_threshold", 64'(want.rms_thr), 64'(seen.rms_thr));
                    check_field("kurtosis_threshold", 64'(want.kurt_level),
                                64'(seen.kurt_level));
                    check_field("windows_learned", 64'(want.windows), 64'(seen.windows));
                    check_field("zero fill", 64'(want.fill), 64'(seen.fill));
                end
                o_verdicts_seen <= o_verdicts_seen + 1;
            end
            if (i_in_valid && i_in_ready)
                expected_verdicts.push_back(
                    judge_window(i_in_user[0],
                                 i_in_data[bsad_pkg::RMS_W-1:0],
                                 i_in_data[bsad_pkg::IN_W-1:bsad_pkg::RMS_W]));
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_verdicts.size();
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;

    localparam int     BASELINE     = 64;
    localparam int     ITEM_TARGET  = 550;
    localparam longint RMS_TOP      = (64'd1 << bsad_pkg::RMS_W) - 1;
    localparam longint KURT_TOP     = (64'd1 << bsad_pkg::KURT_W) - 1;
    localparam logic   CMD_EVALUATE = ~bsad_pkg::CMD_RESTART;

    typedef enum int {
        BASE_CEILING,
        BASE_FLOOR,
        BASE_FULL,
        BASE_TIGHT,
        BASE_MEDIUM
    } t_baseline_shape;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    // rms_value [23:0], kurtosis_value [39:24]
    logic [bsad_pkg::IN_W-1:0]  s_axis_tdata  = '0;
    // command [0]
    logic [0:0]                 s_axis_tuser  = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // status [1:0], alert_cause [3:2], rms_threshold [27:4],
    // kurtosis_threshold [43:28], windows_learned [50:44], zero fill [55:51]
    logic [bsad_pkg::OUT_W-1:0] m_axis_tdata;

    int mismatches;
    int pending;
    int verdicts_seen;
    int items_sent = 0;
    bit steady     = 1'b0;

    baseline_sigma_anomaly_detector #(
        .BASELINE_WINDOWS(BASELINE)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sigma_verdict_checker #(
        .WINDOWS(BASELINE)
    ) verdict_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .i_in_ready      (s_axis_tready),
        .i_in_data       (s_axis_tdata),
        .i_in_user       (s_axis_tuser),
        .i_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .i_out_data      (m_axis_tdata),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_verdicts_seen (verdicts_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic longint clamp(input longint v, input longint hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    function automatic longint jitter(input longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    task automatic send_item(input logic cmd, input longint rms, input longint kurt);
        while (!steady && $urandom_range(0, 99) < 38) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {kurt[bsad_pkg::KURT_W-1:0], rms[bsad_pkg::RMS_W-1:0]};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic await_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
    endtask

    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && verdicts_seen >= 150) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            m_axis_tready <= steady || $urandom_range(0, 99) >= 38;
        end
    end

    initial begin
        longint          rms_c;
        longint          kurt_c;
        longint          rms_s;
        longint          kurt_s;
        longint          rms_v;
        longint          kurt_v;
        t_baseline_shape shape;
        int              seq;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(bsad_pkg::CMD_RESTART, RMS_TOP, KURT_TOP);
        send_item(CMD_EVALUATE, 0, 0);
        send_item(CMD_EVALUATE, RMS_TOP, KURT_TOP);
        send_item(CMD_EVALUATE, RMS_TOP, 0);
        send_item(CMD_EVALUATE, 0, KURT_TOP);
        send_item(CMD_EVALUATE, 'h555555, 'hAAAA);
        send_item(CMD_EVALUATE, 'hAAAAAA, 'h5555);
        send_item(bsad_pkg::CMD_RESTART, 'hAAAAAA, 'h5555);
        send_item(CMD_EVALUATE, 1, 1);
        send_item(bsad_pkg::CMD_RESTART, 0, 0);

        seq = 0;
        while (items_sent < ITEM_TARGET) begin
            if (seq <= int'(BASE_FULL))
                shape = t_baseline_shape'(seq);
            else
                shape = t_baseline_shape'($urandom_range(int'(BASE_FULL), int'(BASE_MEDIUM)));
            steady <= (seq == 3);
            case (shape)
                BASE_CEILING: begin
                    rms_c  = RMS_TOP;
                    kurt_c = KURT_TOP;
                    rms_s  = 0;
                    kurt_s = 0;
                end
                BASE_FLOOR: begin
                    rms_c  = 0;
                    kurt_c = 0;
                    rms_s  = 0;
                    kurt_s = 0;
                end
                BASE_FULL: begin
                    rms_c  = RMS_TOP / 2;
                    kurt_c = KURT_TOP / 2;
                    rms_s  = rms_c + 1;
                    kurt_s = kurt_c + 1;
                end
                BASE_TIGHT: begin
                    rms_c  = longint'($urandom_range(0, 32'(RMS_TOP)));
                    kurt_c = longint'($urandom_range(0, 32'(KURT_TOP)));
                    rms_s  = longint'($urandom_range(0, 20));
                    kurt_s = longint'($urandom_range(0, 40));
                end
                default: begin
                    rms_c  = longint'($urandom_range(0, 32'(RMS_TOP)));
                    kurt_c = longint'($urandom_range(0, 4096));
                    rms_s  = rms_c / longint'($urandom_range(3, 20));
                    kurt_s = longint'($urandom_range(100, 3000));
                end
            endcase

            send_item(bsad_pkg::CMD_RESTART, longint'($urandom), longint'($urandom));
            for (int i = 0; i < BASELINE; i++) begin
                if ($urandom_range(0, 99) == 0)
                    send_item(bsad_pkg::CMD_RESTART, longint'($urandom), longint'($urandom));
                else
                    send_item(CMD_EVALUATE, clamp(rms_c + jitter(rms_s), RMS_TOP),
                              clamp(kurt_c + jitter(kurt_s), KURT_TOP));
            end

            for (int i = int'($urandom_range(20, 50)); i > 0; i--) begin
                if ($urandom_range(0, 99) < 3) begin
                    send_item(bsad_pkg::CMD_RESTART, longint'($urandom), longint'($urandom));
                end else if ($urandom_range(0, 99) < 15) begin
                    send_item(CMD_EVALUATE, longint'($urandom), longint'($urandom));
                end else begin
                    rms_v  = clamp(rms_c * longint'($urandom_range(60, 160)) / 100
                                   + jitter(4 * rms_s), RMS_TOP);
                    kurt_v = clamp(kurt_c + jitter(4 * kurt_s + 800), KURT_TOP);
                    send_item(CMD_EVALUATE, rms_v, kurt_v);
                end
            end

            if (seq == 1)
                await_results();
            seq++;
        end

        await_results();
        repeat (400) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bsad_pkg.sv
design/bsad_mul.sv
design/bsad_div.sv
design/bsad_sqrt.sv
design/baseline_sigma_anomaly_detector.sv
dv/sigma_verdict_checker.sv
dv/testbench.sv
